[src/psi_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and types of the perspective span interpolator.
package psi_pkg;

  localparam int POS_W       = 10;
  localparam int WGT_W       = 24;
  localparam int VAL_W       = 25;
  localparam int FRAC_W      = 4;
  localparam int RES_W       = 32;
  localparam int WEIGHT_FRAC = 40;
  localparam int FRAC_MIN    = 8;
  localparam int FRAC_MAX    = 9;

  localparam int LEN_W       = POS_W + 1;                      // span length, offsets
  localparam int MAG_W       = POS_W;                          // their magnitudes
  localparam int DV_W        = VAL_W + 1;                      // value difference
  localparam int WF_W        = WGT_W + MAG_W;                  // weight times length
  localparam int DIV_NUM_W   = MAG_W + WEIGHT_FRAC + FRAC_MAX; // widest dividend
  localparam int QA_W        = MAG_W + WEIGHT_FRAC;            // start-side quotient
  localparam int SUM_MAG_W   = QA_W + 2;                       // |a + n/2^k|
  localparam int SUM_W       = SUM_MAG_W + 1;
  localparam int LPROD_W     = DV_W + LEN_W;                   // dv * d
  localparam int LNUM_W      = LPROD_W - 2;                    // |dv * d|
  localparam int FPROD_W     = DV_W + RES_W;                   // dv * factor

  typedef struct packed {
    logic signed [POS_W-1:0] span_start;
    logic signed [POS_W-1:0] span_end;
    logic [WGT_W-1:0]        weight_start;
    logic [WGT_W-1:0]        weight_end;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value_start;
    logic signed [VAL_W-1:0] value_end;
    logic [FRAC_W-1:0]       fraction_bits;
    logic                    depth_mode;
    logic                    w_buffer;
  } in_item_t;

  // Per-item control that rides along the whole pipeline.
  typedef struct packed {
    logic signed [VAL_W-1:0] v0;
    logic signed [DV_W-1:0]  dv;
    logic                    kc;     // 0: 8 fraction bits, 1: 9
    logic                    depth;
    logic                    persp;
    logic                    len0;
    logic                    run;    // factor stage is active
    logic                    fault;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    logic n_neg;
  } tag_n_t;

  typedef struct packed {
    ctl_t             ctl;
    logic             fneg;
    logic             szero;
    logic [RES_W-1:0] lq;
  } tag_f_t;

endpackage

[src/psi_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the span items and the interpolated results.
interface psi_in_if;
  import psi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] span_start;
  logic signed [POS_W-1:0] span_end;
  logic [WGT_W-1:0]        weight_start;
  logic [WGT_W-1:0]        weight_end;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value_start;
  logic signed [VAL_W-1:0] value_end;
  logic [FRAC_W-1:0]       fraction_bits;
  logic                    depth_mode;
  logic                    w_buffer;

  modport source (
    output valid, span_start, span_end, weight_start, weight_end, position,
           value_start, value_end, fraction_bits, depth_mode, w_buffer,
    input  ready
  );
  modport sink (
    input  valid, span_start, span_end, weight_start, weight_end, position,
           value_start, value_end, fraction_bits, depth_mode, w_buffer,
    output ready
  );
endinterface

interface psi_out_if;
  import psi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic                    divide_fault;

  modport source (output valid, result_value, divide_fault, input ready);
  modport sink (input valid, result_value, divide_fault, output ready);
endinterface

[src/psi_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage, with a tag.
module psi_div #(
  parameter int NUM_W = psi_pkg::DIV_NUM_W,
  parameter int DEN_W = psi_pkg::WF_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] out_tag
);

  logic             v_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];  // dividend bits left, quotient bits shifted in
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign tag_in = tag;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
      if (en) begin
        rem_r[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[i]  <= {nq_in[NUM_W-2:0], take};
        den_r[i] <= den_in;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign quot      = nq_r[NUM_W-1];
  assign out_tag   = tag_r[NUM_W-1];

endmodule

[src/perspective_span_interpolator.sv]
`timescale 1ns / 1ps
// Top level of the perspective-correct span interpolator pipeline.
//
// Usage: drive one span item per cycle on in_ch (valid/ready). Each item
// yields exactly one result item on out_ch: the interpolated value and a
// flag that a weight product divisor was zero.
// Throughput: one item per clock, sustained, as long as out_ch takes results.
// Pipeline: the item passes 127 register stages, the first loaded at the
// accepting edge: the two chained pipelined dividers (59 stages each:
// dividend bits of |d| * 2^(40+k)) plus three front stages, three between
// the dividers and three for factor, blend multiply and the output register.
// Reset: rst_n low clears every valid bit; no item is in flight afterwards.
// Stall: when out_ch holds a result that is not taken, the whole pipeline
// freezes, unless the stage feeding the output register is empty, in which
// case everything behind it keeps moving and in_ch keeps accepting items.
// Nothing is dropped or repeated on either side.
module perspective_span_interpolator (
  input logic       clk,
  input logic       rst_n,
  psi_in_if.sink    in_ch,
  psi_out_if.source out_ch
);
  import psi_pkg::*;

  // Global advance: every stage before the output register moves together.
  logic en;

  // Stage A: raw input item.
  logic     a_v_r;
  in_item_t a_r;

  logic signed [LEN_W-1:0] a_len;
  logic signed [LEN_W-1:0] a_d;
  logic signed [LEN_W-1:0] a_lmd;
  logic [MAG_W-1:0]        a_len_mag;
  logic signed [DV_W-1:0]  a_dv;
  logic                    a_weq;
  ctl_t                    a_ctl;

  // Stage B: weight products and value product.
  logic                      b_v_r;
  ctl_t                      b_ctl_r;
  logic [MAG_W-1:0]          b_len_mag_r;
  logic                      b_len_neg_r;
  logic signed [LEN_W-1:0]   b_d_r;
  logic signed [LEN_W-1:0]   b_lmd_r;
  logic [WF_W-1:0]           b_wf0_r;
  logic [WF_W-1:0]           b_wf1_r;
  logic signed [LPROD_W-1:0] b_lprod_r;

  logic [MAG_W-1:0]     b_d_mag;
  logic [MAG_W-1:0]     b_lmd_mag;
  logic [DIV_NUM_W-1:0] b_nnum;
  logic [DIV_NUM_W-1:0] b_anum;
  logic [LPROD_W-1:0]   b_lprod_mag;
  logic [RES_W-1:0]     b_lp32;
  logic [RES_W-1:0]     b_lp32_mag;
  logic [LNUM_W-1:0]    b_lnum;
  logic                 b_lneg;

  // Stage C: divider operands.
  logic                 c_v_r;
  tag_n_t               c_tagn_r;
  logic                 c_aneg_r;
  logic                 c_lneg_r;
  logic [DIV_NUM_W-1:0] c_nnum_r;
  logic [DIV_NUM_W-1:0] c_anum_r;
  logic [LNUM_W-1:0]    c_lnum_r;
  logic [WF_W-1:0]      c_wf0_r;
  logic [WF_W-1:0]      c_wf1_r;
  logic [MAG_W-1:0]     c_len_mag_r;

  // First divider outputs.
  logic                 dn_v;
  logic                 da_v;
  logic                 dl_v;
  logic                 d_v;
  logic [DIV_NUM_W-1:0] dn_q;
  logic [DIV_NUM_W-1:0] da_q;
  logic [DIV_NUM_W-1:0] dl_q;
  tag_n_t               dn_tag;
  logic                 da_tag;
  logic                 dl_tag;

  logic signed [DIV_NUM_W:0] d_n;
  logic signed [QA_W:0]      d_a;
  logic [RES_W-1:0]          d_lq;

  // Stage E: signed quotients.
  logic                      e_v_r;
  ctl_t                      e_ctl_r;
  logic signed [DIV_NUM_W:0] e_n_r;
  logic signed [QA_W:0]      e_a_r;
  logic [DIV_NUM_W-1:0]      e_qn_r;
  logic [RES_W-1:0]          e_lq_r;
  logic signed [DIV_NUM_W:0] e_nsh;

  // Stage F: factor divisor sum.
  logic                  f_v_r;
  ctl_t                  f_ctl_r;
  logic signed [SUM_W-1:0] f_sum_r;
  logic [DIV_NUM_W-1:0]  f_qn_r;
  logic                  f_nneg_r;
  logic [RES_W-1:0]      f_lq_r;
  logic [SUM_W-1:0]      f_sum_abs;

  // Stage G: factor divider operands.
  logic                 g_v_r;
  tag_f_t               g_tag_r;
  logic [DIV_NUM_W-1:0] g_qn_r;
  logic [SUM_MAG_W-1:0] g_sabs_r;

  // Final divider outputs.
  logic                 df_v;
  logic [DIV_NUM_W-1:0] df_q;
  tag_f_t               df_tag;
  logic [RES_W-1:0]     df_factor;

  // Stage H: factor.
  logic                    h_v_r;
  ctl_t                    h_ctl_r;
  logic signed [RES_W-1:0] h_factor_r;
  logic [RES_W-1:0]        h_lq_r;

  // Stage I: blend product.
  logic                      i_v_r;
  ctl_t                      i_ctl_r;
  logic signed [FPROD_W-1:0] i_prod_r;
  logic [RES_W-1:0]          i_lq_r;

  logic signed [FPROD_W-1:0] i_dsh;
  logic signed [RES_W-1:0]   i_p32;
  logic signed [RES_W-1:0]   i_ash;
  logic [RES_W-1:0]          i_v0x;
  logic [RES_W-1:0]          i_res;

  // Output register.
  logic             out_v_r;
  logic [RES_W-1:0] out_res_r;
  logic             out_fault_r;

  // Freeze only when a held result would be overwritten.
  assign en          = out_ch.ready | ~out_v_r | ~i_v_r;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------- A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
    end
    if (en) begin
      a_r.span_start    <= in_ch.span_start;
      a_r.span_end      <= in_ch.span_end;
      a_r.weight_start  <= in_ch.weight_start;
      a_r.weight_end    <= in_ch.weight_end;
      a_r.position      <= in_ch.position;
      a_r.value_start   <= in_ch.value_start;
      a_r.value_end     <= in_ch.value_end;
      a_r.fraction_bits <= in_ch.fraction_bits;
      a_r.depth_mode    <= in_ch.depth_mode;
      a_r.w_buffer      <= in_ch.w_buffer;
    end
  end

  // Span geometry, clamp of k, and the mode flags.
  always_comb begin
    a_len     = LEN_W'(a_r.span_end) - LEN_W'(a_r.span_start);
    a_d       = LEN_W'(a_r.position) - LEN_W'(a_r.span_start);
    a_lmd     = LEN_W'(a_r.span_end) - LEN_W'(a_r.position);
    a_len_mag = a_len[LEN_W-1] ? MAG_W'(-a_len) : MAG_W'(a_len);
    a_dv      = DV_W'(a_r.value_end) - DV_W'(a_r.value_start);
    a_weq     = a_r.weight_start == a_r.weight_end;

    a_ctl.v0    = a_r.value_start;
    a_ctl.dv    = a_dv;
    a_ctl.kc    = a_r.fraction_bits >= FRAC_W'(FRAC_MAX);
    a_ctl.depth = a_r.depth_mode;
    a_ctl.persp = !a_weq && (!a_r.depth_mode || a_r.w_buffer);
    a_ctl.len0  = a_len == '0;
    a_ctl.run   = (a_len != '0) && !a_weq;
    // Weight times a nonzero length is zero only for a zero weight.
    a_ctl.fault = a_ctl.run && ((a_r.weight_start == '0) || (a_r.weight_end == '0));
  end

  // ---------------------------------------------------------------- B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_ctl_r     <= a_ctl;
      b_len_mag_r <= a_len_mag;
      b_len_neg_r <= a_len[LEN_W-1];
      b_d_r       <= a_d;
      b_lmd_r     <= a_lmd;
      b_wf0_r     <= WF_W'(a_r.weight_start) * WF_W'(a_len_mag);
      b_wf1_r     <= WF_W'(a_r.weight_end) * WF_W'(a_len_mag);
      b_lprod_r   <= LPROD_W'(a_dv) * LPROD_W'(a_d);
    end
  end

  // Magnitudes and signs for the truncating divisions.
  always_comb begin
    b_d_mag   = b_d_r[LEN_W-1] ? MAG_W'(-b_d_r) : MAG_W'(b_d_r);
    b_lmd_mag = b_lmd_r[LEN_W-1] ? MAG_W'(-b_lmd_r) : MAG_W'(b_lmd_r);
    b_nnum    = b_ctl_r.kc ? (DIV_NUM_W'(b_d_mag) << (WEIGHT_FRAC + FRAC_MAX))
                           : (DIV_NUM_W'(b_d_mag) << (WEIGHT_FRAC + FRAC_MIN));
    b_anum    = DIV_NUM_W'(b_lmd_mag) << WEIGHT_FRAC;

    b_lprod_mag = b_lprod_r[LPROD_W-1] ? LPROD_W'(-b_lprod_r) : LPROD_W'(b_lprod_r);
    b_lp32      = b_lprod_r[RES_W-1:0];
    b_lp32_mag  = b_lp32[RES_W-1] ? (~b_lp32 + RES_W'(1)) : b_lp32;
    // Attribute mode wraps the product to 32 bits before dividing.
    if (b_ctl_r.depth) begin
      b_lnum = b_lprod_mag[LNUM_W-1:0];
      b_lneg = b_lprod_r[LPROD_W-1];
    end else begin
      b_lnum = LNUM_W'(b_lp32_mag);
      b_lneg = b_lp32[RES_W-1];
    end
  end

  // ---------------------------------------------------------------- C
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
    if (en) begin
      c_tagn_r.ctl   <= b_ctl_r;
      c_tagn_r.n_neg <= b_d_r[LEN_W-1] ^ b_len_neg_r;
      c_aneg_r       <= b_lmd_r[LEN_W-1] ^ b_len_neg_r;
      c_lneg_r       <= b_lneg ^ b_len_neg_r;
      c_nnum_r       <= b_nnum;
      c_anum_r       <= b_anum;
      c_lnum_r       <= b_lnum;
      c_wf0_r        <= b_wf0_r;
      c_wf1_r        <= b_wf1_r;
      c_len_mag_r    <= b_len_mag_r;
    end
  end

  // End-side quotient n, start-side quotient a, linear quotient.
  psi_div #(.NUM_W(DIV_NUM_W), .DEN_W(WF_W), .TAG_W($bits(tag_n_t))) u_div_n (
    .clk, .rst_n, .en,
    .in_valid(c_v_r), .num(c_nnum_r), .den(c_wf1_r), .tag(c_tagn_r),
    .out_valid(dn_v), .quot(dn_q), .out_tag(dn_tag)
  );

  psi_div #(.NUM_W(DIV_NUM_W), .DEN_W(WF_W), .TAG_W(1)) u_div_a (
    .clk, .rst_n, .en,
    .in_valid(c_v_r), .num(c_anum_r), .den(c_wf0_r), .tag(c_aneg_r),
    .out_valid(da_v), .quot(da_q), .out_tag(da_tag)
  );

  psi_div #(.NUM_W(DIV_NUM_W), .DEN_W(MAG_W), .TAG_W(1)) u_div_l (
    .clk, .rst_n, .en,
    .in_valid(c_v_r), .num(DIV_NUM_W'(c_lnum_r)), .den(c_len_mag_r), .tag(c_lneg_r),
    .out_valid(dl_v), .quot(dl_q), .out_tag(dl_tag)
  );

  assign d_v = dn_v & da_v & dl_v;

  // Reapply signs; only the low 32 bits of the linear quotient matter.
  always_comb begin
    d_n  = dn_tag.n_neg ? -$signed({1'b0, dn_q}) : $signed({1'b0, dn_q});
    d_a  = da_tag ? -$signed({1'b0, da_q[QA_W-1:0]}) : $signed({1'b0, da_q[QA_W-1:0]});
    d_lq = dl_tag ? (~dl_q[RES_W-1:0] + RES_W'(1)) : dl_q[RES_W-1:0];
  end

  // ---------------------------------------------------------------- E
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v;
    end
    if (en) begin
      e_ctl_r <= dn_tag.ctl;
      e_n_r   <= d_n;
      e_a_r   <= d_a;
      e_qn_r  <= dn_q;
      e_lq_r  <= d_lq;
    end
  end

  // Arithmetic shift gives the floor of n / 2^k.
  assign e_nsh = e_ctl_r.kc ? (e_n_r >>> FRAC_MAX) : (e_n_r >>> FRAC_MIN);

  // ---------------------------------------------------------------- F
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= e_v_r;
    end
    if (en) begin
      f_ctl_r  <= e_ctl_r;
      f_sum_r  <= SUM_W'(e_a_r) + SUM_W'(e_nsh);
      f_qn_r   <= e_qn_r;
      f_nneg_r <= e_n_r[DIV_NUM_W];
      f_lq_r   <= e_lq_r;
    end
  end

  assign f_sum_abs = f_sum_r[SUM_W-1] ? SUM_W'(-f_sum_r) : SUM_W'(f_sum_r);

  // ---------------------------------------------------------------- G
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f_v_r;
    end
    if (en) begin
      g_tag_r.ctl   <= f_ctl_r;
      g_tag_r.fneg  <= f_nneg_r ^ f_sum_r[SUM_W-1];
      g_tag_r.szero <= f_sum_r == '0;
      g_tag_r.lq    <= f_lq_r;
      g_qn_r        <= f_qn_r;
      g_sabs_r      <= f_sum_abs[SUM_MAG_W-1:0];
    end
  end

  // factor = n / (a + floor(n / 2^k))
  psi_div #(.NUM_W(DIV_NUM_W), .DEN_W(SUM_MAG_W), .TAG_W($bits(tag_f_t))) u_div_f (
    .clk, .rst_n, .en,
    .in_valid(g_v_r), .num(g_qn_r), .den(g_sabs_r), .tag(g_tag_r),
    .out_valid(df_v), .quot(df_q), .out_tag(df_tag)
  );

  // Drop the factor to zero when the stage is off, faulted or the sum is zero.
  always_comb begin
    if (!df_tag.ctl.run || df_tag.ctl.fault || df_tag.szero) begin
      df_factor = '0;
    end else if (df_tag.fneg) begin
      df_factor = ~df_q[RES_W-1:0] + RES_W'(1);
    end else begin
      df_factor = df_q[RES_W-1:0];
    end
  end

  // ---------------------------------------------------------------- H
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= df_v;
    end
    if (en) begin
      h_ctl_r    <= df_tag.ctl;
      h_factor_r <= $signed(df_factor);
      h_lq_r     <= df_tag.lq;
    end
  end

  // ---------------------------------------------------------------- I
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_v_r <= 1'b0;
    end else if (en) begin
      i_v_r <= h_v_r;
    end
    if (en) begin
      i_ctl_r  <= h_ctl_r;
      i_prod_r <= FPROD_W'(h_ctl_r.dv) * FPROD_W'(h_factor_r);
      i_lq_r   <= h_lq_r;
    end
  end

  // Blend: depth shifts the full product, attribute the wrapped 32-bit one.
  always_comb begin
    i_dsh = i_ctl_r.kc ? (i_prod_r >>> FRAC_MAX) : (i_prod_r >>> FRAC_MIN);
    i_p32 = $signed(i_prod_r[RES_W-1:0]);
    i_ash = i_ctl_r.kc ? (i_p32 >>> FRAC_MAX) : (i_p32 >>> FRAC_MIN);
    i_v0x = RES_W'(i_ctl_r.v0);
    if (i_ctl_r.len0) begin
      i_res = i_v0x;
    end else if (i_ctl_r.persp) begin
      i_res = i_ctl_r.depth ? (i_v0x + i_dsh[RES_W-1:0]) : (i_v0x + RES_W'(i_ash));
    end else begin
      i_res = i_v0x + i_lq_r;
    end
  end

  // ---------------------------------------------------------------- out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= i_v_r;
    end
    if (!out_v_r || out_ch.ready) begin
      out_res_r   <= i_res;
      out_fault_r <= i_ctl_r.fault;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_value = $signed(out_res_r);
  assign out_ch.divide_fault = out_fault_r;

`ifndef NO_ASSERTIONS
  // The three parallel dividers must stay in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dn_v == da_v) && (dn_v == dl_v))
    else $error("parallel dividers out of step");

  // An accepted item lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> a_v_r)
    else $error("accepted item lost at entry");

  // A held result with a full feeding stage freezes that stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready && i_v_r) |=> (i_v_r && $stable(i_prod_r)))
    else $error("blend stage moved under a stall");

  // Without an active, fault-free factor stage the factor is zero.
  a_factor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (h_v_r && (!h_ctl_r.run || h_ctl_r.fault)) |-> (h_factor_r == '0))
    else $error("nonzero factor outside factor stage");
`endif

endmodule
